@@ src/hcd_pkg.sv @@
// ----------------------------------------------------------------------------
// hcd_pkg
// Shared types and constants of the HTTP chunked transfer decoder.
// ----------------------------------------------------------------------------
package hcd_pkg;

  // Width of the chunk length counter.
  localparam int LEN_BITS = 32;

  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;

  // Status codes reported with every result item.
  localparam logic [2:0] ST_RUNNING  = 3'd0;
  localparam logic [2:0] ST_DONE     = 3'd1;
  localparam logic [2:0] ST_BAD_BYTE = 3'd2;
  localparam logic [2:0] ST_EARLY_END = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  typedef enum logic [10:0] {
    PH_START    = 11'b000_0000_0001,
    PH_LEAD_LF  = 11'b000_0000_0010,
    PH_DIGITS   = 11'b000_0000_0100,
    PH_HDR_LF   = 11'b000_0000_1000,
    PH_PAYLOAD  = 11'b000_0001_0000,
    PH_TRL_CR   = 11'b000_0010_0000,
    PH_TRL_LF   = 11'b000_0100_0000,
    PH_DONE     = 11'b000_1000_0000,
    PH_ERR_BYTE = 11'b001_0000_0000,
    PH_ERR_END  = 11'b010_0000_0000,
    PH_ERR_OVF  = 11'b100_0000_0000
  } phase_t;

  typedef struct packed {
    phase_t              phase;
    logic [LEN_BITS-1:0] remaining;
    logic                final_chunk;
  } dec_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic [2:0] status;
  } dec_result_t;

endpackage

@@ src/hcd_ifs.sv @@
// ----------------------------------------------------------------------------
// hcd_ifs
// Valid/ready channels of the chunked decoder: byte input and result output.
// ----------------------------------------------------------------------------
interface hcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface hcd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic [2:0] status;

  modport source (output valid, output out_byte, output out_valid, output status,
                  input ready);
  modport sink   (input valid, input out_byte, input out_valid, input status,
                  output ready);
endinterface

@@ src/hcd_step.sv @@
// ----------------------------------------------------------------------------
// hcd_step
// Next-state and result logic of the decoder for one stream byte.
// ----------------------------------------------------------------------------
module hcd_step
  import hcd_pkg::*;
(
  input  dec_state_t  cur,
  input  logic [7:0]  data_byte,
  input  logic        end_of_input,
  output dec_state_t  nxt,
  output dec_result_t res
);

  logic                is_hex;
  logic [3:0]          digit;
  logic                len_full;
  logic [LEN_BITS-1:0] len_shifted;
  logic [LEN_BITS-1:0] len_dec;
  logic                running;
  logic                err;
  phase_t              err_phase;

  // Hex digit decode in either letter case.
  always_comb begin
    is_hex = 1'b1;
    digit  = 4'd0;
    if (data_byte >= CH_ZERO && data_byte <= CH_NINE) begin
      digit = 4'(data_byte - CH_ZERO);
    end else if (data_byte >= CH_LOW_A && data_byte <= CH_LOW_F) begin
      digit = 4'(data_byte - CH_LOW_A + 8'd10);
    end else if (data_byte >= CH_UP_A && data_byte <= CH_UP_F) begin
      digit = 4'(data_byte - CH_UP_A + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  // Another digit would push set bits out of the top nibble.
  assign len_full    = (cur.remaining[LEN_BITS-1 -: 4] != 4'd0);
  assign len_shifted = {cur.remaining[LEN_BITS-5:0], digit};
  assign len_dec     = cur.remaining - LEN_BITS'(1);

  assign running = (cur.phase != PH_DONE) && (cur.phase != PH_ERR_BYTE) &&
                   (cur.phase != PH_ERR_END) && (cur.phase != PH_ERR_OVF);

  always_comb begin
    nxt           = cur;
    res.out_byte  = 8'd0;
    res.out_valid = 1'b0;
    err           = 1'b1;
    err_phase     = PH_ERR_BYTE;

    if (!running) begin
      err = 1'b0;
    end else if (end_of_input) begin
      err       = 1'b0;
      nxt.phase = PH_ERR_END;
    end else begin
      case (cur.phase)
        PH_START, PH_LEAD_LF, PH_DIGITS: begin
          if (is_hex) begin
            if (len_full) begin
              err_phase = PH_ERR_OVF;
            end else begin
              err           = 1'b0;
              nxt.remaining = len_shifted;
              nxt.phase     = PH_DIGITS;
            end
          end else if (cur.phase == PH_START && data_byte == CH_CR) begin
            err       = 1'b0;
            nxt.phase = PH_LEAD_LF;
          end else if (cur.phase == PH_LEAD_LF && data_byte == CH_LF) begin
            err       = 1'b0;
            nxt.phase = PH_DIGITS;
          end else if (cur.phase == PH_DIGITS && data_byte == CH_CR) begin
            err       = 1'b0;
            nxt.phase = PH_HDR_LF;
          end
        end
        PH_HDR_LF: begin
          if (data_byte == CH_LF) begin
            err = 1'b0;
            if (cur.remaining == '0) begin
              nxt.final_chunk = 1'b1;
              nxt.phase       = PH_TRL_CR;
            end else begin
              nxt.phase = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          err           = 1'b0;
          res.out_byte  = data_byte;
          res.out_valid = 1'b1;
          nxt.remaining = len_dec;
          if (len_dec == '0) begin
            nxt.phase = PH_TRL_CR;
          end
        end
        PH_TRL_CR: begin
          if (data_byte == CH_CR) begin
            err       = 1'b0;
            nxt.phase = PH_TRL_LF;
          end
        end
        PH_TRL_LF: begin
          if (data_byte == CH_LF) begin
            err = 1'b0;
            if (cur.final_chunk) begin
              nxt.phase = PH_DONE;
            end else begin
              nxt.remaining = '0;
              nxt.phase     = PH_DIGITS;
            end
          end
        end
        default: begin
          err = 1'b0;
        end
      endcase

      if (err) begin
        nxt.phase     = err_phase;
        nxt.remaining = cur.remaining;
        res.out_byte  = data_byte;
        res.out_valid = 1'b0;
      end
    end

    // Status reflects the phase after this byte.
    case (nxt.phase)
      PH_DONE:     res.status = ST_DONE;
      PH_ERR_BYTE: res.status = ST_BAD_BYTE;
      PH_ERR_END:  res.status = ST_EARLY_END;
      PH_ERR_OVF:  res.status = ST_OVERFLOW;
      default:     res.status = ST_RUNNING;
    endcase
  end

endmodule

@@ src/http_chunked_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// http_chunked_decoder_unit
// HTTP chunked transfer decoder: one result item for every input byte item.
// ----------------------------------------------------------------------------
// The unit takes one item per clock cycle while in_ch.ready is high and
// returns exactly one result item for each, in order: an input register
// holds the byte, the decode logic updates the parser state, and a result
// register presents out_byte, out_valid and status. Only items with
// out_valid set carry payload bytes; the others report header and trailer
// progress or the sticky error. A stalled output does not block the input
// at once: the input register can still take one more item while the
// result waits, after which in_ch.ready drops until the result is taken.
// The length counter is LEN_BITS wide; a hex length that does not fit
// reports an overflow status.
module http_chunked_decoder_unit
  import hcd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  hcd_in_if.sink           in_ch,
  hcd_out_if.source        out_ch
);

  // Input register stage.
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_eoi_r;

  // Parser state, updated when the staged item moves to the result register.
  dec_state_t  st_r;
  dec_state_t  st_nxt;

  // Result register.
  logic        res_valid_r;
  dec_result_t res_r;
  dec_result_t res_nxt;

  logic        res_free;
  logic        s1_move;
  logic        in_take;

  // The result register can load when it is empty or being drained.
  assign res_free = !res_valid_r || out_ch.ready;
  assign s1_move  = s1_valid_r && res_free;
  assign in_ch.ready = !s1_valid_r || res_free;
  assign in_take  = in_ch.valid && in_ch.ready;

  hcd_step u_step (
    .cur          (st_r),
    .data_byte    (s1_byte_r),
    .end_of_input (s1_eoi_r),
    .nxt          (st_nxt),
    .res          (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r        <= 1'b0;
      res_valid_r       <= 1'b0;
      st_r.phase        <= PH_START;
      st_r.remaining    <= '0;
      st_r.final_chunk  <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_move) begin
        res_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_ch.ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_ch.data_byte;
      s1_eoi_r  <= in_ch.end_of_input;
    end
    if (s1_move) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid     = res_valid_r;
  assign out_ch.out_byte  = res_r.out_byte;
  assign out_ch.out_valid = res_r.out_valid;
  assign out_ch.status    = res_r.status;

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives chunked byte streams into http_chunked_decoder_unit and checks every
// result item against a cycle-free model of the decoder or a hand-written
// expectation, under random input bursts and output stalls.
// ----------------------------------------------------------------------------
// The run has a single reset. Because every error is sticky, each run ends its
// stream in one way only, picked at random: a normal final chunk, a final
// chunk with an empty length field, a bad framing byte, an early end of input
// or a length that does not fit the counter. Items offered after that end
// check that the decoder keeps its final status.
module testbench;
  import hcd_pkg::*;

  // One item of the input stream. Directed rows may carry a hand-written
  // expectation; all other items are checked against the decoder model.
  typedef struct packed {
    logic [7:0]  data;
    logic        eoi;
    logic        typed;
    dec_result_t want;
  } feed_item_t;

  typedef enum int {
    FIN_DONE,
    FIN_EMPTY_LEN,
    FIN_BAD_BYTE,
    FIN_EARLY,
    FIN_OVERFLOW
  } finish_t;

  // Directed opening: optional lead CR LF (the second row is sometimes swapped
  // for a digit, which the decoder also allows right after the lead CR), a
  // length with more leading zeros than the counter holds digits, payload
  // bytes at both extremes and payload bytes that look like CR and LF.
  localparam feed_item_t DIRECTED [25] = '{
    '{CH_CR,   1'b0, 1'b1, '{8'h00, 1'b0, ST_RUNNING}},
    '{CH_LF,   1'b0, 1'b1, '{8'h00, 1'b0, ST_RUNNING}},
    '{CH_ZERO, 1'b0, 1'b0, '0},
    '{CH_ZERO, 1'b0, 1'b0, '0},
    '{CH_ZERO, 1'b0, 1'b0, '0},
    '{CH_ZERO, 1'b0, 1'b0, '0},
    '{CH_ZERO, 1'b0, 1'b0, '0},
    '{CH_ZERO, 1'b0, 1'b0, '0},
    '{CH_ZERO, 1'b0, 1'b0, '0},
    '{CH_ZERO, 1'b0, 1'b0, '0},
    '{CH_ZERO, 1'b0, 1'b0, '0},
    '{8'h33,   1'b0, 1'b0, '0},
    '{CH_CR,   1'b0, 1'b0, '0},
    '{CH_LF,   1'b0, 1'b1, '{8'h00, 1'b0, ST_RUNNING}},
    '{8'h00,   1'b0, 1'b1, '{8'h00, 1'b1, ST_RUNNING}},
    '{8'hFF,   1'b0, 1'b1, '{8'hFF, 1'b1, ST_RUNNING}},
    '{CH_LF,   1'b0, 1'b1, '{CH_LF, 1'b1, ST_RUNNING}},
    '{CH_CR,   1'b0, 1'b1, '{8'h00, 1'b0, ST_RUNNING}},
    '{CH_LF,   1'b0, 1'b1, '{8'h00, 1'b0, ST_RUNNING}},
    '{8'h31,   1'b0, 1'b0, '0},
    '{CH_CR,   1'b0, 1'b0, '0},
    '{CH_LF,   1'b0, 1'b1, '{8'h00, 1'b0, ST_RUNNING}},
    '{CH_CR,   1'b0, 1'b1, '{CH_CR, 1'b1, ST_RUNNING}},
    '{CH_CR,   1'b0, 1'b1, '{8'h00, 1'b0, ST_RUNNING}},
    '{CH_LF,   1'b0, 1'b1, '{8'h00, 1'b0, ST_RUNNING}}
  };

  logic clk = 1'b0;
  logic rst_n;

  hcd_in_if  in_ch ();
  hcd_out_if out_ch ();

  http_chunked_decoder_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  feed_item_t  feed_q [$];     // every item the sender will offer, in order
  int          framing_pos [$]; // indexes of header and trailer bytes in feed_q
  dec_result_t want_q [$];      // result items still owed by the decoder
  dec_result_t predicted;
  dec_result_t oldest;
  int          accept_idx    = 0;
  int          results_taken = 0;
  int          fail_count    = 0;

  // Decoder model state.
  phase_t              dec_phase;
  logic [LEN_BITS-1:0] chunk_left;
  logic                last_chunk;

  function automatic logic is_hex_char(input logic [7:0] b);
    return (b >= CH_ZERO && b <= CH_NINE) || (b >= CH_LOW_A && b <= CH_LOW_F) ||
           (b >= CH_UP_A && b <= CH_UP_F);
  endfunction

  // Advances the model by one input item and returns the result item it owes.
  function automatic dec_result_t decode_byte(input logic [7:0] b, input logic eoi);
    dec_result_t r;
    logic [7:0]  digit;
    logic        ok;
    phase_t      fault;
    r = '0;
    if (dec_phase != PH_DONE && dec_phase != PH_ERR_BYTE && dec_phase != PH_ERR_END &&
        dec_phase != PH_ERR_OVF) begin
      if (eoi) begin
        dec_phase = PH_ERR_END;
      end else begin
        ok = 1'b0;
        fault = PH_ERR_BYTE;
        if (is_hex_char(b) && (dec_phase == PH_START || dec_phase == PH_LEAD_LF ||
                               dec_phase == PH_DIGITS)) begin
          digit = (b <= CH_NINE) ? b - CH_ZERO : (b | 8'h20) - CH_LOW_A + 8'd10;
          // A digit may not push set bits out of the top of the counter.
          if (chunk_left[LEN_BITS-1 -: 4] != 4'h0) begin
            fault = PH_ERR_OVF;
          end else begin
            chunk_left = {chunk_left[LEN_BITS-5:0], digit[3:0]};
            ok = 1'b1;
          end
          dec_phase = PH_DIGITS;
        end else begin
          case (dec_phase)
            PH_START: begin
              if (b == CH_CR) begin
                ok = 1'b1;
                dec_phase = PH_LEAD_LF;
              end
            end
            PH_LEAD_LF: begin
              if (b == CH_LF) begin
                ok = 1'b1;
                dec_phase = PH_DIGITS;
              end
            end
            PH_DIGITS: begin
              if (b == CH_CR) begin
                ok = 1'b1;
                dec_phase = PH_HDR_LF;
              end
            end
            PH_HDR_LF: begin
              if (b == CH_LF) begin
                ok = 1'b1;
                if (chunk_left == '0) begin
                  last_chunk = 1'b1;
                  dec_phase = PH_TRL_CR;
                end else begin
                  dec_phase = PH_PAYLOAD;
                end
              end
            end
            PH_PAYLOAD: begin
              ok = 1'b1;
              r.out_byte = b;
              r.out_valid = 1'b1;
              chunk_left = chunk_left - LEN_BITS'(1);
              if (chunk_left == '0) dec_phase = PH_TRL_CR;
            end
            PH_TRL_CR: begin
              if (b == CH_CR) begin
                ok = 1'b1;
                dec_phase = PH_TRL_LF;
              end
            end
            default: begin
              if (b == CH_LF) begin
                ok = 1'b1;
                if (last_chunk) begin
                  dec_phase = PH_DONE;
                end else begin
                  chunk_left = '0;
                  dec_phase = PH_DIGITS;
                end
              end
            end
          endcase
        end
        if (!ok) begin
          dec_phase = fault;
          r.out_byte = b;
          r.out_valid = 1'b0;
        end
      end
    end
    case (dec_phase)
      PH_DONE:     r.status = ST_DONE;
      PH_ERR_BYTE: r.status = ST_BAD_BYTE;
      PH_ERR_END:  r.status = ST_EARLY_END;
      PH_ERR_OVF:  r.status = ST_OVERFLOW;
      default:     r.status = ST_RUNNING;
    endcase
    return r;
  endfunction

  // Hex digit character for a nibble, letters in a random case.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return CH_ZERO + {4'h0, nib};
    return ($urandom_range(0, 1) ? CH_UP_A : CH_LOW_A) + {4'h0, nib} - 8'd10;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic framing);
    feed_item_t it;
    it = '0;
    it.data = b;
    feed_q.push_back(it);
    if (framing) framing_pos.push_back(feed_q.size() - 1);
  endtask

  // One chunk: optional leading zeros, the length in hex, CR LF, random
  // payload, CR LF. A zero length with no zeros gives an empty length field.
  task automatic add_chunk(input logic [31:0] len, input int zeros);
    logic started;
    started = 1'b0;
    for (int k = 0; k < zeros; k++) push_byte(CH_ZERO, 1'b1);
    for (int s = 28; s >= 0; s -= 4) begin
      if (len[s +: 4] != 4'h0 || started) begin
        started = 1'b1;
        push_byte(hex_char(len[s +: 4]), 1'b1);
      end
    end
    push_byte(CH_CR, 1'b1);
    push_byte(CH_LF, 1'b1);
    for (int k = 0; k < len; k++) push_byte(8'($urandom_range(0, 255)), 1'b0);
    push_byte(CH_CR, 1'b1);
    push_byte(CH_LF, 1'b1);
  endtask

  task automatic build_stream();
    feed_item_t it;
    finish_t    fin;
    int         tail_start;
    int         first;
    int         cut;
    int         pick;
    logic [7:0] junk;

    for (int i = 0; i < 25; i++) begin
      it = DIRECTED[i];
      if (i == 1 && $urandom_range(0, 1)) it.data = CH_ZERO;
      feed_q.push_back(it);
    end

    // Well-formed body: mostly short chunks, a few long ones, and lengths
    // written with varying numbers of leading zeros.
    while (feed_q.size() < 1550) begin
      pick = $urandom_range(0, 9);
      add_chunk($urandom_range(0, 19) == 0 ? $urandom_range(100, 300) : $urandom_range(1, 24),
                pick < 7 ? 0 : (pick < 9 ? $urandom_range(1, 2) : $urandom_range(3, 12)));
    end

    tail_start = feed_q.size();
    add_chunk($urandom_range(1, 6), 0);
    fin = finish_t'($urandom_range(0, 4));
    case (fin)
      FIN_DONE: begin
        add_chunk(0, $urandom_range(1, 3));
      end
      FIN_EMPTY_LEN: begin
        add_chunk(0, 0);
      end
      FIN_BAD_BYTE: begin
        // Replace one framing byte of the tail with a byte that no header or
        // trailer position accepts.
        add_chunk(0, 1);
        first = 0;
        while (framing_pos[first] < tail_start) first++;
        cut = framing_pos[$urandom_range(first, framing_pos.size() - 1)];
        while (feed_q.size() > cut) feed_q.delete(feed_q.size() - 1);
        do begin
          junk = 8'($urandom_range(0, 255));
        end while (is_hex_char(junk) || junk == CH_CR || junk == CH_LF);
        push_byte(junk, 1'b1);
      end
      FIN_EARLY: begin
        add_chunk(0, 1);
        cut = $urandom_range(tail_start, feed_q.size() - 1);
        while (feed_q.size() > cut) feed_q.delete(feed_q.size() - 1);
        it = '0;
        it.data = 8'($urandom_range(0, 255));
        it.eoi = 1'b1;
        feed_q.push_back(it);
      end
      default: begin
        // Nine significant digits: the ninth one no longer fits.
        for (int k = $urandom_range(0, 3); k > 0; k--) push_byte(CH_ZERO, 1'b1);
        push_byte(hex_char(4'($urandom_range(1, 15))), 1'b1);
        for (int k = 0; k < 8; k++) push_byte(hex_char(4'($urandom_range(0, 15))), 1'b1);
      end
    endcase

    // After the stream has ended the decoder must hold its final status.
    for (int k = 0; k < 24; k++) begin
      it = '0;
      it.data = 8'($urandom_range(0, 255));
      it.eoi = (k == 23) || ($urandom_range(0, 3) == 0);
      feed_q.push_back(it);
    end
  endtask

  // Input acceptance and result checking share one process so that an item
  // accepted and a result taken at the same edge are handled in a fixed order.
  always @(posedge clk) begin
    if (!rst_n) begin
      dec_phase = PH_START;
      chunk_left = '0;
      last_chunk = 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predicted = decode_byte(in_ch.data_byte, in_ch.end_of_input);
        if (feed_q[accept_idx].typed) want_q.push_back(feed_q[accept_idx].want);
        else want_q.push_back(predicted);
        accept_idx++;
      end
      if (out_ch.valid && out_ch.ready) begin
        results_taken++;
        if (want_q.size() == 0) begin
          $error("unexpected result item: out_byte %02h out_valid %0b status %0d",
                 out_ch.out_byte, out_ch.out_valid, out_ch.status);
          fail_count++;
        end else begin
          oldest = want_q.pop_front();
          if (out_ch.out_byte !== oldest.out_byte) begin
            $error("out_byte: expected %02h, got %02h", oldest.out_byte, out_ch.out_byte);
            fail_count++;
          end
          if (out_ch.out_valid !== oldest.out_valid) begin
            $error("out_valid: expected %0b, got %0b", oldest.out_valid, out_ch.out_valid);
            fail_count++;
          end
          if (out_ch.status !== oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, out_ch.status);
            fail_count++;
          end
        end
      end
    end
  end

  // Sender: bursts of random length separated by random gaps, some of them
  // empty. Inputs change on the falling edge only.
  initial begin
    int idx;
    int burst_left;
    int gap_len;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.end_of_input = 1'b0;
    rst_n = 1'b0;
    build_stream();
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    idx = 0;
    burst_left = 0;
    while (idx < feed_q.size()) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 48);
        case ($urandom_range(0, 3))
          0:       gap_len = 0;
          3:       gap_len = $urandom_range(4, 12);
          default: gap_len = $urandom_range(1, 3);
        endcase
        if (gap_len > 0) begin
          in_ch.valid = 1'b0;
          repeat (gap_len) @(negedge clk);
        end
      end
      in_ch.valid = 1'b1;
      in_ch.data_byte = feed_q[idx].data;
      in_ch.end_of_input = feed_q[idx].eoi;
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      idx++;
      burst_left--;
      @(negedge clk);
    end
    in_ch.valid = 1'b0;

    // Drain, then give the pipeline a few more cycles to show any stray item.
    while (want_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  // Receiver: the stall pattern is redrawn at regular intervals from always
  // ready, a fixed one-in-five stall and two random densities. Once, well into
  // the body of the stream, it holds off for a long stretch so that the
  // decoder fills and has to stall its input.
  initial begin
    int   tick;
    int   stall_mode;
    logic held_once;
    tick = 0;
    stall_mode = 0;
    held_once = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!held_once && results_taken >= 500) begin
        held_once = 1'b1;
        out_ch.ready = 1'b0;
        repeat (80) @(negedge clk);
      end
      tick++;
      if (tick % 128 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0:       out_ch.ready = 1'b1;
        1:       out_ch.ready = (tick % 5) != 0;
        2:       out_ch.ready = $urandom_range(0, 1);
        default: out_ch.ready = $urandom_range(0, 4) == 0;
      endcase
    end
  end

  // A hung handshake ends the run here. A correct run at the slowest stall
  // and gap settings takes a small fraction of this.
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ http_chunked_decoder_unit.f @@
src/hcd_pkg.sv
src/hcd_ifs.sv
src/hcd_step.sv
src/http_chunked_decoder_unit.sv
tb/testbench.sv
